// ----- rtl/core/tprp_pkg.sv -----
package tprp_pkg;

	localparam logic [7:0] MASK_BASE = 8'h80;
	localparam logic [7:0] ROW_TERM  = 8'h00;
	localparam logic [5:0] CHANNEL_COUNT_RESET = 6'd8;
	localparam int unsigned SEQ_LEN = 6;
	localparam logic [4:0] FLUSH_MAX = 5'd31;

	typedef struct packed {
		logic [7:0] note;
		logic [7:0] instrument;
		logic [7:0] volume;
		logic [7:0] effect;
		logic [7:0] effect_param;
	} cell_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} beat_t;

	// one cell's work for the back end: lone mask bytes first, then the enabled bytes
	typedef struct packed {
		logic [4:0]              flush;
		logic [SEQ_LEN-1:0]      en;
		logic [SEQ_LEN-1:0][7:0] bytes;
	} cmd_t;

	typedef struct packed {
		logic push;
	} qwr_t;

	typedef struct packed {
		logic nonempty;
	} qrd_t;

endpackage

// ----- rtl/core/tprp_front.sv -----
module tprp_front #(
	parameter int MAX_CHANNELS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  tprp_pkg::cell_t      in_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [5:0]           cfg_data,
	output tprp_pkg::qwr_t       qwr,
	input  logic                 q_full,
	output tprp_pkg::cmd_t       cmd
);

	localparam logic [5:0] MAX_CH = 6'(MAX_CHANNELS);

	logic [5:0] chan_cnt_q;
	logic [5:0] pend_q;
	logic [5:0] pos_q;
	logic [5:0] eff_cnt;
	logic       accept;
	logic       row_end;
	logic       empty;
	logic       raw;
	logic [3:0] m;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;

	always_comb begin
		eff_cnt = (chan_cnt_q == 6'd0) ? 6'd1 : chan_cnt_q;
		if (eff_cnt > MAX_CH) begin
			eff_cnt = MAX_CH;
		end
	end

	assign row_end = ({1'b0, pos_q} + 7'd1) >= {1'b0, eff_cnt};
	assign empty   = (in_data.note | in_data.instrument | in_data.volume |
		in_data.effect | in_data.effect_param) == 8'd0;
	assign raw     = (in_data.note != 8'd0) && (in_data.instrument != 8'd0) &&
		(in_data.volume != 8'd0) && (in_data.effect != 8'd0);
	assign m = {(in_data.effect | in_data.effect_param) != 8'd0,
		in_data.volume != 8'd0, in_data.instrument != 8'd0, in_data.note != 8'd0};

	always_comb begin
		cmd.flush = 5'd0;
		cmd.en    = '0;
		cmd.bytes = '0;
		if (empty) begin
			cmd.en[0]    = 1'b1;
			cmd.bytes[0] = tprp_pkg::ROW_TERM;
		end else begin
			cmd.flush    = pend_q[5] ? tprp_pkg::FLUSH_MAX : pend_q[4:0];
			if (raw) begin
				cmd.en       = 6'b011111;
				cmd.bytes[0] = in_data.note;
				cmd.bytes[1] = in_data.instrument;
				cmd.bytes[2] = in_data.volume;
				cmd.bytes[3] = in_data.effect;
				cmd.bytes[4] = in_data.effect_param;
			end else begin
				cmd.en       = {m[3], m[3], m[2], m[1], m[0], 1'b1};
				cmd.bytes[0] = tprp_pkg::MASK_BASE | {4'd0, m};
				cmd.bytes[1] = in_data.note;
				cmd.bytes[2] = in_data.instrument;
				cmd.bytes[3] = in_data.volume;
				cmd.bytes[4] = in_data.effect;
				cmd.bytes[5] = in_data.effect_param;
			end
		end
	end

	// an empty cell inside the row leaves nothing for the back end
	assign qwr.push = accept && !(empty && !row_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_cnt_q <= tprp_pkg::CHANNEL_COUNT_RESET;
			pend_q     <= 6'd0;
			pos_q      <= 6'd0;
		end else begin
			if (cfg_valid) begin
				chan_cnt_q <= cfg_data;
			end
			if (accept) begin
				if (row_end) begin
					pend_q <= 6'd0;
					pos_q  <= 6'd0;
				end else begin
					pos_q <= pos_q + 6'd1;
					if (!empty) begin
						pend_q <= 6'd0;
					end else if (pend_q != 6'd63) begin
						pend_q <= pend_q + 6'd1;
					end
				end
			end
		end
	end

endmodule

// ----- rtl/core/tprp_queue.sv -----
module tprp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  tprp_pkg::qwr_t wr,
	input  tprp_pkg::cmd_t wr_data,
	output logic           full,
	input  logic           pop,
	output tprp_pkg::qrd_t rd,
	output tprp_pkg::cmd_t rd_data
);

	tprp_pkg::cmd_t mem_q [2];
	logic           wptr_q;
	logic           rptr_q;
	logic [1:0]     cnt_q;
	logic           do_pop;

	assign full        = cnt_q == 2'd2;
	assign rd.nonempty = cnt_q != 2'd0;
	assign do_pop      = pop && (cnt_q != 2'd0);
	assign rd_data     = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr.push) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (wr.push) begin
				wptr_q <= !wptr_q;
			end
			if (do_pop) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, wr.push} - {1'b0, do_pop};
		end
	end

endmodule

// ----- rtl/core/tprp_back.sv -----
module tprp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  tprp_pkg::qrd_t qrd,
	input  tprp_pkg::cmd_t head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output tprp_pkg::beat_t out_data
);

	logic                                      busy_q;
	logic [4:0]                                flush_q;
	logic [tprp_pkg::SEQ_LEN-1:0]              en_q;
	logic [tprp_pkg::SEQ_LEN-1:0][7:0]         bytes_q;
	logic                                      out_valid_q;
	tprp_pkg::beat_t                           out_q;
	logic                                      slot_free;
	logic [2:0]                                sel;
	logic [tprp_pkg::SEQ_LEN-1:0]              en_rest;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign slot_free = !out_valid_q || !out_stall;
	assign pop       = !busy_q && qrd.nonempty;

	// lowest enabled byte goes next
	always_comb begin
		sel = 3'd0;
		for (int i = tprp_pkg::SEQ_LEN - 1; i >= 0; i--) begin
			if (en_q[i]) begin
				sel = 3'(i);
			end
		end
		en_rest = en_q & ~(6'b000001 << sel);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bytes_q <= head.bytes;
		end
		if (busy_q && slot_free) begin
			if (flush_q != 5'd0) begin
				out_q.out_byte    <= tprp_pkg::MASK_BASE;
				out_q.last_of_run <= 1'b0;
			end else begin
				out_q.out_byte    <= bytes_q[sel];
				out_q.last_of_run <= en_rest == '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			flush_q     <= 5'd0;
			en_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (slot_free) begin
				out_valid_q <= busy_q;
			end
			if (pop) begin
				busy_q  <= 1'b1;
				flush_q <= head.flush;
				en_q    <= head.en;
			end else if (busy_q && slot_free) begin
				if (flush_q != 5'd0) begin
					flush_q <= flush_q - 5'd1;
				end else begin
					en_q <= en_rest;
					if (en_rest == '0) begin
						busy_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule

// ----- rtl/core/tracker_pattern_row_packer_top.sv -----
// Packs tracker pattern cells, given one per beat in row-major order, into the packed
// pattern byte stream, one byte per output beat with last_of_run on the final byte of a
// cell. The front end takes a cell and updates the row position and the count of
// held-back empty cells; a two-entry queue decouples it from the back end, which sends
// one byte per cycle while out_stall is low. A cell yields its flushed lone mask bytes
// and then its enabled bytes; the back end pops the next cell from the queue only
// after the last byte of the current one, and the single output byte lane sets the
// rate. An empty cell inside a row yields no beat. A write to the channel count takes
// effect on the next cell; write it only while the block is idle.
module tracker_pattern_row_packer_top #(
	parameter int MAX_CHANNELS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  tprp_pkg::cell_t  in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output tprp_pkg::beat_t  out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [5:0]       cfg_data
);

	tprp_pkg::qwr_t qwr;
	tprp_pkg::qrd_t qrd;
	tprp_pkg::cmd_t cmd_in;
	tprp_pkg::cmd_t cmd_head;
	logic           q_full;
	logic           pop;

	tprp_front #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.qwr      (qwr),
		.q_full   (q_full),
		.cmd      (cmd_in)
	);

	tprp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (qwr),
		.wr_data(cmd_in),
		.full   (q_full),
		.pop    (pop),
		.rd     (qrd),
		.rd_data(cmd_head)
	);

	tprp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qrd      (qrd),
		.head     (cmd_head),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule
